FILE: design/spim_pkg.sv
// ----------------------------------------------------------------------------
// spim_pkg
// Shared types, register indexes and the divider helper for the SPI master.
// ----------------------------------------------------------------------------
package spim_pkg;

  localparam int WORD_BITS_DEF = 16;
  localparam int TX_W          = 16;
  localparam int RX_W          = 16;
  localparam int DIV_W         = 9;
  localparam int HALF_W        = 10;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_WORD_SIXTEEN    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_IDLE_HIGH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUT_ON_ACT_IDLE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_AT_END   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRIMARY         = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECONDARY       = 3'd5;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic       word_sixteen;
    logic       clock_idle_high;
    logic       out_on_active_to_idle;
    logic       sample_at_end;
    logic [1:0] primary_prescale;
    logic [2:0] secondary_prescale;
  } cfg_t;

  typedef struct packed {
    logic            sck_level;
    logic            mosi_bit;
    logic            select_n;
    logic [RX_W-1:0] rx_word;
    logic            rx_full;
    logic            busy_res;
  } res_t;

  // primary (64/16/4/1) times secondary (8 - code); the primary is a shift
  function automatic logic [HALF_W-1:0] half_ticks(input logic [1:0] prim,
                                                   input logic [2:0] sec);
    logic [3:0] s;
    s = 4'd8 - {1'b0, sec};
    case (prim)
      2'd0:    half_ticks = {s, 6'b0};
      2'd1:    half_ticks = {2'b0, s, 4'b0};
      2'd2:    half_ticks = {4'b0, s, 2'b0};
      default: half_ticks = {6'b0, s};
    endcase
  endfunction

endpackage

FILE: design/spim_core.sv
// ----------------------------------------------------------------------------
// spim_core
// Shifter, bit counter, clock divider and burst state; one update per transfer.
// ----------------------------------------------------------------------------
module spim_core #(
  parameter int WORD_BITS = spim_pkg::WORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic                     op,
  input  logic [spim_pkg::TX_W-1:0] tx_word,
  input  logic                     last_word,
  input  logic                     miso_bit,
  input  spim_pkg::cfg_t           cfg,
  output spim_pkg::res_t           res
);

  localparam int BL_W = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0]       shift_out_r, shift_out_nxt;
  logic [WORD_BITS-1:0]       shift_in_r, shift_in_nxt;
  logic [BL_W-1:0]            bits_left_r, bits_left_nxt;
  logic [spim_pkg::DIV_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                       phase_r, phase_nxt;
  logic [spim_pkg::RX_W-1:0]  rx_hold_r, rx_hold_nxt;
  logic                       rx_full_r, rx_full_nxt;
  logic                       burst_r, burst_nxt;
  logic                       close_r, close_nxt;

  logic [spim_pkg::DIV_W-1:0]  cnt_inc;
  logic [spim_pkg::HALF_W-1:0] half;
  logic                        half_end;
  logic [WORD_BITS-1:0]        shift_in_s;
  logic                        active_first, active;

  assign cnt_inc  = div_cnt_r + 1'b1;
  assign half     = spim_pkg::half_ticks(cfg.primary_prescale, cfg.secondary_prescale);
  assign half_end = ({1'b0, cnt_inc} >= half) || (cnt_inc == '0);

  always_comb begin
    shift_out_nxt = shift_out_r;
    shift_in_nxt  = shift_in_r;
    bits_left_nxt = bits_left_r;
    div_cnt_nxt   = div_cnt_r;
    phase_nxt     = phase_r;
    rx_hold_nxt   = rx_hold_r;
    rx_full_nxt   = rx_full_r;
    burst_nxt     = burst_r;
    close_nxt     = close_r;
    shift_in_s    = {shift_in_r[WORD_BITS-2:0], miso_bit};
    if (op == spim_pkg::OP_WRITE) begin
      if (bits_left_r == '0) begin
        if (cfg.word_sixteen) begin
          shift_out_nxt = WORD_BITS'(tx_word);
          bits_left_nxt = BL_W'(WORD_BITS);
        end else begin
          shift_out_nxt = {tx_word[7:0], {(WORD_BITS-8){1'b0}}};
          bits_left_nxt = BL_W'(8);
        end
        shift_in_nxt = '0;
        div_cnt_nxt  = '0;
        phase_nxt    = 1'b0;
        rx_full_nxt  = 1'b0;
        burst_nxt    = 1'b1;
        close_nxt    = last_word;
      end
    end else if (bits_left_r != '0) begin
      div_cnt_nxt = cnt_inc;
      if (half_end) begin
        div_cnt_nxt = '0;
        if (!phase_r) begin
          phase_nxt = 1'b1;
          if (!cfg.sample_at_end) begin
            shift_in_nxt = shift_in_s;
          end
        end else begin
          phase_nxt = 1'b0;
          if (cfg.sample_at_end) begin
            shift_in_nxt = shift_in_s;
          end
          shift_out_nxt = {shift_out_r[WORD_BITS-2:0], 1'b0};
          bits_left_nxt = bits_left_r - 1'b1;
          if (bits_left_r == BL_W'(1)) begin
            rx_hold_nxt = shift_in_nxt[spim_pkg::RX_W-1:0];
            rx_full_nxt = 1'b1;
            if (close_r) begin
              burst_nxt = 1'b0;
              close_nxt = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_out_r <= '0;
      shift_in_r  <= '0;
      bits_left_r <= '0;
      div_cnt_r   <= '0;
      phase_r     <= 1'b0;
      rx_hold_r   <= '0;
      rx_full_r   <= 1'b0;
      burst_r     <= 1'b0;
      close_r     <= 1'b0;
    end else if (step) begin
      shift_out_r <= shift_out_nxt;
      shift_in_r  <= shift_in_nxt;
      bits_left_r <= bits_left_nxt;
      div_cnt_r   <= div_cnt_nxt;
      phase_r     <= phase_nxt;
      rx_hold_r   <= rx_hold_nxt;
      rx_full_r   <= rx_full_nxt;
      burst_r     <= burst_nxt;
      close_r     <= close_nxt;
    end
  end

  assign active_first = !cfg.out_on_active_to_idle;
  assign active       = phase_nxt ? !active_first : active_first;

  always_comb begin
    res.busy_res  = (bits_left_nxt != '0);
    res.sck_level = res.busy_res ? (active ^ cfg.clock_idle_high) : cfg.clock_idle_high;
    res.mosi_bit  = res.busy_res ? shift_out_nxt[WORD_BITS-1] : 1'b0;
    res.select_n  = !burst_nxt;
    res.rx_word   = rx_hold_nxt;
    res.rx_full   = rx_full_nxt;
  end

endmodule

FILE: design/spi_master_burst_shifter.sv
// ----------------------------------------------------------------------------
// spi_master_burst_shifter
// SPI master, modes 0-3, 8/16-bit words, with input and result registers.
// ----------------------------------------------------------------------------
//  channel | signals                                   | transfer when
//  in      | in_op in_tx_word in_last_word in_miso_bit | in_valid & in_ready
//  out     | out_sck_level .. out_busy_res             | out_valid & out_ready
//  cfg     | cfg_we cfg_index cfg_data                 | cfg_we
//
//  One transfer per cycle while no result is stalled; a result passes the input
//  register, then one update of the shifter state into the result reg, and
//  is valid from there.
//  Reset clears valid flags and core state; the configuration resets to zero.
//  A stalled result holds the pipe; in_ready drops only when both stages hold.
// ----------------------------------------------------------------------------
module spi_master_burst_shifter #(
  parameter int WORD_BITS = spim_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic [spim_pkg::TX_W-1:0]       in_tx_word,
  input  logic                            in_last_word,
  input  logic                            in_miso_bit,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_sck_level,
  output logic                            out_mosi_bit,
  output logic                            out_select_n,
  output logic [spim_pkg::RX_W-1:0]       out_rx_word,
  output logic                            out_rx_full,
  output logic                            out_busy_res,
  input  logic                            cfg_we,
  input  logic [spim_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spim_pkg::CFG_DATA_W-1:0]  cfg_data
);

  spim_pkg::cfg_t cfg_r;

  logic                      in_valid_r;
  logic                      op_r, last_r, miso_r;
  logic [spim_pkg::TX_W-1:0] tx_r;
  logic                      out_valid_r;
  spim_pkg::res_t            res, res_r;
  logic                      advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spim_pkg::CFG_WORD_SIXTEEN:    cfg_r.word_sixteen          <= cfg_data[0];
        spim_pkg::CFG_CLOCK_IDLE_HIGH: cfg_r.clock_idle_high       <= cfg_data[0];
        spim_pkg::CFG_OUT_ON_ACT_IDLE: cfg_r.out_on_active_to_idle <= cfg_data[0];
        spim_pkg::CFG_SAMPLE_AT_END:   cfg_r.sample_at_end         <= cfg_data[0];
        spim_pkg::CFG_PRIMARY:         cfg_r.primary_prescale      <= cfg_data[1:0];
        spim_pkg::CFG_SECONDARY:       cfg_r.secondary_prescale    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_r   <= in_op;
      tx_r   <= in_tx_word;
      last_r <= in_last_word;
      miso_r <= in_miso_bit;
    end
  end

  spim_core #(
    .WORD_BITS(WORD_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .op        (op_r),
    .tx_word   (tx_r),
    .last_word (last_r),
    .miso_bit  (miso_r),
    .cfg       (cfg_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sck_level = res_r.sck_level;
  assign out_mosi_bit  = res_r.mosi_bit;
  assign out_select_n  = res_r.select_n;
  assign out_rx_word   = res_r.rx_word;
  assign out_rx_full   = res_r.rx_full;
  assign out_busy_res  = res_r.busy_res;

endmodule

FILE: design/spim_checker.sv
// ----------------------------------------------------------------------------
// spim_checker
// Port-level checks for the SPI master, bound to the top level.
// ----------------------------------------------------------------------------
module spim_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_sck_level,
  input logic                      out_mosi_bit,
  input logic                      out_select_n,
  input logic [spim_pkg::RX_W-1:0] out_rx_word,
  input logic                      out_rx_full,
  input logic                      out_busy_res
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rx_word)
      && $stable(out_sck_level) && $stable(out_select_n) && $stable(out_busy_res)
      && $stable(out_mosi_bit) && $stable(out_rx_full))
    else $error("stalled result changed");

  a_mosi_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> !out_mosi_bit)
    else $error("mosi driven while idle");

  a_busy_select: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_busy_res |-> !out_select_n)
    else $error("word shifting with chip select released");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

endmodule

bind spi_master_burst_shifter spim_checker u_spim_checker (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the SPI master burst shifter. Drives write and tick transfers
// through a valid/ready channel with random gaps, predicts every result in a
// bit-level model of the SCK, MOSI, chip select and receive logic, and checks
// each result transfer against it under random output stalls. The settings
// move across word sizes, all clock modes and divider extremes, some of them
// taking effect while a word is still being shifted.
// ----------------------------------------------------------------------------
module tb;

  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic                      op;
    logic [spim_pkg::TX_W-1:0] tx_word;
    logic                      last_word;
    logic                      miso_bit;
  } spi_req_t;

  logic                             clk;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             in_op = spim_pkg::OP_TICK;
  logic [spim_pkg::TX_W-1:0]        in_tx_word = '0;
  logic                             in_last_word = 1'b0;
  logic                             in_miso_bit = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             out_sck_level;
  logic                             out_mosi_bit;
  logic                             out_select_n;
  logic [spim_pkg::RX_W-1:0]        out_rx_word;
  logic                             out_rx_full;
  logic                             out_busy_res;
  logic                             cfg_we = 1'b0;
  logic [spim_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [spim_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  spi_req_t       pending_transfers[$];
  spim_pkg::res_t predicted_results[$];
  spi_req_t       next_req;
  spim_pkg::res_t got_res;
  spim_pkg::res_t want_res;
  int             queued;
  int             mismatches = 0;
  int             quiet_cycles = 0;
  int             send_gap = 0;
  int             stall_left = 0;
  logic           calm = 1'b0;

  // predicted shifter state and settings
  spim_pkg::cfg_t                  pcfg = '0;
  logic [15:0]                     p_shift_out = '0;
  logic [15:0]                     p_shift_in = '0;
  logic [4:0]                      p_bits_left = '0;
  logic [spim_pkg::DIV_W-1:0]      p_div = '0;
  logic                            p_phase = 1'b0;
  logic [spim_pkg::RX_W-1:0]       p_hold = '0;
  logic                            p_full = 1'b0;
  logic                            p_burst = 1'b0;
  logic                            p_close = 1'b0;

  spi_master_burst_shifter dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_tx_word   (in_tx_word),
    .in_last_word (in_last_word),
    .in_miso_bit  (in_miso_bit),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sck_level(out_sck_level),
    .out_mosi_bit (out_mosi_bit),
    .out_select_n (out_select_n),
    .out_rx_word  (out_rx_word),
    .out_rx_full  (out_rx_full),
    .out_busy_res (out_busy_res),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned half_len(input spim_pkg::cfg_t c);
    return (32'd64 >> (2 * c.primary_prescale)) * (32'd8 - c.secondary_prescale);
  endfunction

  function automatic spim_pkg::res_t advance_spi(input logic op,
                                                 input logic [spim_pkg::TX_W-1:0] tx,
                                                 input logic last, input logic miso);
    spim_pkg::res_t r;
    if (op == spim_pkg::OP_WRITE) begin
      if (p_bits_left == '0) begin
        if (pcfg.word_sixteen) begin
          p_shift_out = tx;
          p_bits_left = 5'd16;
        end else begin
          p_shift_out = {tx[7:0], 8'h00};
          p_bits_left = 5'd8;
        end
        p_shift_in = '0;
        p_div      = '0;
        p_phase    = 1'b0;
        p_full     = 1'b0;
        p_burst    = 1'b1;
        p_close    = last;
      end
    end else if (p_bits_left != '0) begin
      p_div = p_div + 1'b1;
      if (p_div >= half_len(pcfg) || p_div == '0) begin
        p_div = '0;
        if (!p_phase) begin
          p_phase = 1'b1;
          if (!pcfg.sample_at_end) p_shift_in = {p_shift_in[14:0], miso};
        end else begin
          p_phase = 1'b0;
          if (pcfg.sample_at_end) p_shift_in = {p_shift_in[14:0], miso};
          p_shift_out = p_shift_out << 1;
          p_bits_left = p_bits_left - 1'b1;
          if (p_bits_left == '0) begin
            p_hold = p_shift_in;
            p_full = 1'b1;
            if (p_close) begin
              p_burst = 1'b0;
              p_close = 1'b0;
            end
          end
        end
      end
    end
    r.sck_level = pcfg.clock_idle_high ^
                  ((p_bits_left != '0) & (p_phase ^ ~pcfg.out_on_active_to_idle));
    r.mosi_bit  = (p_bits_left != '0) & p_shift_out[15];
    r.select_n  = ~p_burst;
    r.rx_word   = p_hold;
    r.rx_full   = p_full;
    r.busy_res  = (p_bits_left != '0);
    return r;
  endfunction

  task automatic note_mismatch(input string tag, input spim_pkg::res_t want,
                               input spim_pkg::res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected sck %b mosi %b sel_n %b rx %h full %b busy %b", tag,
               want.sck_level, want.mosi_bit, want.select_n, want.rx_word,
               want.rx_full, want.busy_res);
      $display("%s: actual   sck %b mosi %b sel_n %b rx %h full %b busy %b", tag,
               got.sck_level, got.mosi_bit, got.select_n, got.rx_word,
               got.rx_full, got.busy_res);
    end
  endtask

  task automatic push_req(input logic op, input logic [spim_pkg::TX_W-1:0] tx,
                          input logic last, input logic miso);
    spi_req_t req;
    req.op        = op;
    req.tx_word   = tx;
    req.last_word = last;
    req.miso_bit  = miso;
    pending_transfers.push_back(req);
    queued++;
  endtask

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++)
      push_req(spim_pkg::OP_TICK, 16'($urandom), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
  endtask

  task automatic write_reg(input logic [spim_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [spim_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_settings(input spim_pkg::cfg_t c);
    write_reg(spim_pkg::CFG_WORD_SIXTEEN, {2'b0, c.word_sixteen});
    write_reg(spim_pkg::CFG_CLOCK_IDLE_HIGH, {2'b0, c.clock_idle_high});
    write_reg(spim_pkg::CFG_OUT_ON_ACT_IDLE, {2'b0, c.out_on_active_to_idle});
    write_reg(spim_pkg::CFG_SAMPLE_AT_END, {2'b0, c.sample_at_end});
    write_reg(spim_pkg::CFG_PRIMARY, {1'b0, c.primary_prescale});
    write_reg(spim_pkg::CFG_SECONDARY, c.secondary_prescale);
    pcfg = c;
  endtask

  // hold until every queued transfer has gone through and every result is back
  task automatic drain();
    do @(negedge clk);
    while (pending_transfers.size() != 0 || in_valid || predicted_results.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic queue_random_phase(input int budget);
    int pick;
    queued = 0;
    while (queued < budget) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        push_req(spim_pkg::OP_WRITE, 16'($urandom), $urandom_range(0, 2) == 0,
                 1'($urandom_range(0, 1)));
        if (pick == 0)
          push_req(spim_pkg::OP_WRITE, 16'($urandom), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        push_ticks(int'(2 * half_len(pcfg) * (pcfg.word_sixteen ? 16 : 8)
                        + $urandom_range(0, 2)));
      end else if (pick == 8) begin
        push_ticks($urandom_range(1, 4));
      end else begin
        push_req(spim_pkg::OP_WRITE, 16'($urandom), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
        push_ticks(int'($urandom_range(1, half_len(pcfg) * 8)));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready)
        predicted_results.push_back(advance_spi(in_op, in_tx_word, in_last_word,
                                                in_miso_bit));
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          send_gap <= $urandom_range(0, 8);
          in_valid <= 1'b0;
        end else if (pending_transfers.size() != 0) begin
          next_req = pending_transfers.pop_front();
          in_op        <= next_req.op;
          in_tx_word   <= next_req.tx_word;
          in_last_word <= next_req.last_word;
          in_miso_bit  <= next_req.miso_bit;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got_res = {out_sck_level, out_mosi_bit, out_select_n, out_rx_word,
                   out_rx_full, out_busy_res};
        if (predicted_results.size() == 0) begin
          note_mismatch("unpredicted result", '0, got_res);
        end else begin
          want_res = predicted_results.pop_front();
          if (got_res !== want_res) note_mismatch("result mismatch", want_res, got_res);
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 8);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    spim_pkg::cfg_t c;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // mode 0, byte words, fastest divider
    c = '0;
    c.primary_prescale   = 2'd3;
    c.secondary_prescale = 3'd7;
    load_settings(c);
    push_req(spim_pkg::OP_TICK, 16'hFFFF, 1'b1, 1'b1);
    push_req(spim_pkg::OP_WRITE, 16'hFFFF, 1'b0, 1'b1);
    push_req(spim_pkg::OP_WRITE, 16'h0000, 1'b1, 1'b0);
    for (int i = 0; i < 16; i++) push_req(spim_pkg::OP_TICK, 16'h0000, 1'b0, 1'b1);
    push_req(spim_pkg::OP_WRITE, 16'h0000, 1'b1, 1'b0);
    for (int i = 0; i < 16; i++) push_req(spim_pkg::OP_TICK, 16'hFFFF, 1'b1, 1'b0);
    push_req(spim_pkg::OP_TICK, 16'h0000, 1'b0, 1'b0);
    drain();

    // slowest divider; leave the word open so the next setting cuts the half short
    load_settings('0);
    push_req(spim_pkg::OP_WRITE, 16'($urandom), 1'b1, 1'b0);
    push_req(spim_pkg::OP_WRITE, 16'($urandom), 1'b0, 1'b1);
    push_ticks(530);
    drain();

    load_settings('1);
    queue_random_phase(40);
    drain();

    c = '0;
    c.clock_idle_high    = 1'b1;
    c.sample_at_end      = 1'b1;
    c.primary_prescale   = 2'd2;
    c.secondary_prescale = 3'd7;
    load_settings(c);
    queue_random_phase(40);
    drain();

    c = '0;
    c.out_on_active_to_idle = 1'b1;
    c.primary_prescale      = 2'd2;
    c.secondary_prescale    = 3'd6;
    load_settings(c);
    queue_random_phase(40);
    drain();

    for (int p = 0; p < 4; p++) begin
      c.word_sixteen          = 1'($urandom_range(0, 1));
      c.clock_idle_high       = 1'($urandom_range(0, 1));
      c.out_on_active_to_idle = 1'($urandom_range(0, 1));
      c.sample_at_end         = 1'($urandom_range(0, 1));
      c.primary_prescale      = 2'd3;
      c.secondary_prescale    = 3'($urandom_range(4, 7));
      if (p >= 3) calm = 1'b1;
      load_settings(c);
      queue_random_phase(20);
      drain();
    end

    repeat (4) @(negedge clk);
    if (mismatches == 0 && predicted_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: spi_master_burst_shifter.f
design/spim_pkg.sv
design/spim_core.sv
design/spi_master_burst_shifter.sv
design/spim_checker.sv
tb/sv/tb.sv
